>>> src/twpd_pkg.sv
// Shared types, codes and the pad neighbor table of the wipe detector.
package twpd_pkg;

   // Wipe edge codes
   localparam logic [1:0] EDGE_LEFT   = 2'd0;
   localparam logic [1:0] EDGE_TOP    = 2'd1;
   localparam logic [1:0] EDGE_BOTTOM = 2'd2;
   localparam logic [1:0] EDGE_RIGHT  = 2'd3;

   // Rotation sense codes
   localparam logic DIR_CW  = 1'b0;
   localparam logic DIR_ACW = 1'b1;

   localparam int PADS        = 4;
   localparam int SLOTS       = 8;   // two neighbor checks per pad
   localparam int QUEUE_DEPTH = 4;

   localparam logic [7:0] LIMIT_RESET = 8'd20;

   typedef struct packed {
      logic       face;
      logic [3:0] pad_bits;
   } req_type;

   typedef struct packed {
      logic       event_face;
      logic [1:0] edge_res;
      logic       direction;
      logic       last_event;
   } rsp_type;

   // One classified request: face and the neighbor checks that fired
   typedef struct packed {
      logic                   face;
      logic [SLOTS-1:0] fire;
   } entry_type;

   typedef struct packed {
      logic [1:0] pad;
      logic [1:0] edge_code;
      logic       dir;
   } nb_type;

   // Slot s checks neighbor (s & 1) of pad (s >> 1)
   function automatic nb_type nb_lookup(input logic [2:0] slot);
      nb_type nb;
      case (slot)
         3'd0:    nb = '{pad: 2'd1, edge_code: EDGE_LEFT,   dir: DIR_ACW};
         3'd1:    nb = '{pad: 2'd2, edge_code: EDGE_TOP,    dir: DIR_CW};
         3'd2:    nb = '{pad: 2'd0, edge_code: EDGE_LEFT,   dir: DIR_CW};
         3'd3:    nb = '{pad: 2'd3, edge_code: EDGE_BOTTOM, dir: DIR_ACW};
         3'd4:    nb = '{pad: 2'd0, edge_code: EDGE_TOP,    dir: DIR_ACW};
         3'd5:    nb = '{pad: 2'd3, edge_code: EDGE_RIGHT,  dir: DIR_CW};
         3'd6:    nb = '{pad: 2'd1, edge_code: EDGE_BOTTOM, dir: DIR_CW};
         3'd7:    nb = '{pad: 2'd2, edge_code: EDGE_RIGHT,  dir: DIR_ACW};
         default: nb = '{pad: 2'd0, edge_code: EDGE_LEFT,   dir: DIR_CW};
      endcase
      return nb;
   endfunction

endpackage

>>> src/twpd_front.sv
// Front end: release counters per face and classification of each request.
module twpd_front #(
   parameter int NUM_FACES = 2
) (
   input  logic                clock,
   input  logic                reset,
   input  logic                accept,
   input  twpd_pkg::req_type   req,
   input  logic [7:0]          limit,
   output logic                push,
   output twpd_pkg::entry_type entry
);
   import twpd_pkg::*;

   logic [PADS-1:0][7:0] cnt_ff [NUM_FACES];
   logic [PADS-1:0][7:0] cnt_cur;
   logic [PADS-1:0][7:0] cnt_in;
   logic [SLOTS-1:0]     fire;
   logic                 face_ok;

   assign face_ok = (int'(req.face) < NUM_FACES);

   // Select the counters of the addressed face
   always_comb begin
      cnt_cur = '1;
      for (int f = 0; f < NUM_FACES; f++) begin
         if (int'(req.face) == f) begin
            cnt_cur = cnt_ff[f];
         end
      end
   end

   // Advance counters, then walk the neighbor checks in order
   always_comb begin
      logic [PADS-1:0] done;
      nb_type          nb;
      for (int p = 0; p < PADS; p++) begin
         if (req.pad_bits[p]) begin
            cnt_in[p] = 8'd0;
         end else if (cnt_cur[p] < limit) begin
            cnt_in[p] = cnt_cur[p] + 8'd1;
         end else begin
            cnt_in[p] = cnt_cur[p];
         end
         done[p] = (cnt_in[p] >= limit);
      end
      fire = '0;
      for (int s = 0; s < SLOTS; s++) begin
         nb = nb_lookup(3'(s));
         if (req.pad_bits[s / 2] && !done[nb.pad]) begin
            fire[s]        = 1'b1;
            done[nb.pad]   = 1'b1;
            cnt_in[nb.pad] = limit;
         end
      end
   end

   // Queue only requests that raise at least one event
   assign push       = accept && face_ok && (fire != '0);
   assign entry.face = req.face;
   assign entry.fire = fire;

   // Hold counters; update the addressed face on each accepted request
   always_ff @(posedge clock) begin
      for (int f = 0; f < NUM_FACES; f++) begin
         if (reset) begin
            cnt_ff[f] <= '1;
         end else if (accept && face_ok && int'(req.face) == f) begin
            cnt_ff[f] <= cnt_in;
         end
      end
   end

endmodule

>>> src/twpd_queue.sv
// Short queue of classified requests between front and back end.
module twpd_queue (
   input  logic                clock,
   input  logic                reset,
   input  logic                push,
   input  twpd_pkg::entry_type push_entry,
   output logic                full,
   input  logic                pop,
   output twpd_pkg::entry_type pop_entry,
   output logic                empty
);
   import twpd_pkg::*;

   localparam int PTR_W = $clog2(QUEUE_DEPTH);
   localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

   entry_type        slot_ff [QUEUE_DEPTH];
   logic [PTR_W-1:0] wr_ptr_ff;
   logic [PTR_W-1:0] rd_ptr_ff;
   logic [CNT_W-1:0] count_ff;
   logic [CNT_W-1:0] count_in;

   assign full      = (count_ff == CNT_W'(QUEUE_DEPTH));
   assign empty     = (count_ff == '0);
   assign pop_entry = slot_ff[rd_ptr_ff];

   // Track fill level
   always_comb begin
      count_in = count_ff;
      if (push && !pop) begin
         count_in = count_ff + CNT_W'(1);
      end else if (pop && !push) begin
         count_in = count_ff - CNT_W'(1);
      end
   end

   // Advance pointers and hold fill level
   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         if (push) begin
            wr_ptr_ff <= wr_ptr_ff + PTR_W'(1);
         end
         if (pop) begin
            rd_ptr_ff <= rd_ptr_ff + PTR_W'(1);
         end
         count_ff <= count_in;
      end
   end

   // Store entries
   always_ff @(posedge clock) begin
      if (push) begin
         slot_ff[wr_ptr_ff] <= push_entry;
      end
   end

endmodule

>>> src/twpd_back.sv
// Back end: hands out the events of one classified request, one per cycle while rsp_pop is high.
module twpd_back (
   input  logic                clock,
   input  logic                reset,
   input  logic                q_empty,
   input  twpd_pkg::entry_type q_entry,
   output logic                q_pop,
   input  logic                rsp_pop,
   output logic                rsp_empty,
   output twpd_pkg::rsp_type   rsp_data
);
   import twpd_pkg::*;

   logic             cur_valid_ff;
   logic             cur_valid_in;
   logic             cur_face_ff;
   logic             cur_face_in;
   logic [SLOTS-1:0] cur_fire_ff;
   logic [SLOTS-1:0] cur_fire_in;
   logic [2:0]       sel;
   logic             last;
   logic             take;
   nb_type           nb;

   // Pick the lowest-numbered pending event slot
   always_comb begin
      sel = '0;
      for (int s = SLOTS - 1; s >= 0; s--) begin
         if (cur_fire_ff[s]) begin
            sel = 3'(s);
         end
      end
   end

   assign last  = ((cur_fire_ff & (cur_fire_ff - SLOTS'(1))) == '0);
   assign take  = cur_valid_ff && rsp_pop;
   assign q_pop = !q_empty && (!cur_valid_ff || (take && last));

   // Load next request, drop served events
   always_comb begin
      cur_valid_in = cur_valid_ff;
      cur_face_in  = cur_face_ff;
      cur_fire_in  = cur_fire_ff;
      if (q_pop) begin
         cur_valid_in = 1'b1;
         cur_face_in  = q_entry.face;
         cur_fire_in  = q_entry.fire;
      end else if (take && last) begin
         cur_valid_in = 1'b0;
      end else if (take) begin
         cur_fire_in[sel] = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cur_valid_ff <= 1'b0;
      end else begin
         cur_valid_ff <= cur_valid_in;
      end
      cur_face_ff <= cur_face_in;
      cur_fire_ff <= cur_fire_in;
   end

   // Drive the result outputs
   assign nb                  = nb_lookup(sel);
   assign rsp_empty           = !cur_valid_ff;
   assign rsp_data.event_face = cur_face_ff;
   assign rsp_data.edge_res   = nb.edge_code;
   assign rsp_data.direction  = nb.dir;
   assign rsp_data.last_event = last;

endmodule

>>> src/touch_pad_wipe_detector_unit.sv
// Top level of the touch pad wipe detector: front end, queue, back end.
// An accepted request goes to a queue slot, then to the back-end current register,
// which shows its first event on rsp_*. One request per cycle while not full; events
// leave one per cycle while rsp_pop is high, and the four-entry queue absorbs bursts.
// Reset: counters read all ones (no pad recently released), limit returns to 20,
// queue and result stage empty. No clearing pass.
module touch_pad_wipe_detector_unit #(
   parameter int NUM_FACES = 2
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_push,
   output logic              req_full,
   input  twpd_pkg::req_type req_data,
   output logic              rsp_empty,
   input  logic              rsp_pop,
   output twpd_pkg::rsp_type rsp_data,
   input  logic              csr_we,
   input  logic [7:0]        csr_wdata
);
   import twpd_pkg::*;

   logic [7:0] limit_ff;
   logic       accept;
   logic       q_push;
   logic       q_full;
   logic       q_pop;
   logic       q_empty;
   entry_type  q_in;
   entry_type  q_out;

   // Hold the limit register
   always_ff @(posedge clock) begin
      if (reset) begin
         limit_ff <= LIMIT_RESET;
      end else if (csr_we) begin
         limit_ff <= csr_wdata;
      end
   end

   assign req_full = q_full;
   assign accept   = req_push && !q_full;

   twpd_front #(
      .NUM_FACES(NUM_FACES)
   ) u_front (
      .clock (clock),
      .reset (reset),
      .accept(accept),
      .req   (req_data),
      .limit (limit_ff),
      .push  (q_push),
      .entry (q_in)
   );

   twpd_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (q_push),
      .push_entry(q_in),
      .full      (q_full),
      .pop       (q_pop),
      .pop_entry (q_out),
      .empty     (q_empty)
   );

   twpd_back u_back (
      .clock    (clock),
      .reset    (reset),
      .q_empty  (q_empty),
      .q_entry  (q_out),
      .q_pop    (q_pop),
      .rsp_pop  (rsp_pop),
      .rsp_empty(rsp_empty),
      .rsp_data (rsp_data)
   );

   // Never push into a full queue
   assert property (@(posedge clock) disable iff (reset) q_push |-> !q_full)
      else $error("push into full queue");

   // Only requests with events are queued
   assert property (@(posedge clock) disable iff (reset) q_push |-> (q_in.fire != '0))
      else $error("queued request without events");

   // Never pop an empty queue
   assert property (@(posedge clock) disable iff (reset) q_pop |-> !q_empty)
      else $error("pop from empty queue");

   // A limit write lands on the next cycle
   assert property (@(posedge clock) disable iff (reset)
                    csr_we |=> (limit_ff == $past(csr_wdata)))
      else $error("limit write lost");

endmodule

>>> tb/sv/touch_pad_wipe_detector_unit_checker.sv
// Checker for the wipe detector: predicts wipe events and compares them.
`timescale 1ns / 1ps

module touch_pad_wipe_detector_unit_checker #(
   parameter int NUM_FACES = 2
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_push,
   input  logic              req_full,
   input  twpd_pkg::req_type req_data,
   input  logic              rsp_empty,
   input  logic              rsp_pop,
   input  twpd_pkg::rsp_type rsp_data,
   input  logic              csr_we,
   input  logic [7:0]        csr_wdata,
   output int                pending,
   output int                mismatches,
   output int                events_checked
);
   import twpd_pkg::*;

   logic [7:0] off_time [NUM_FACES][PADS];
   logic [7:0] elapse_limit;
   rsp_type    expected_wipes [$];

   // Map neighbor j of a pad to the pad it names, the edge and the rotation sense
   task automatic neighbor_of(input int pad, input int j, output int nb_pad,
                              output logic [1:0] edge_code, output logic dir);
      case ({pad[1:0], j[0]})
         3'b000: begin nb_pad = 1; edge_code = EDGE_LEFT;   dir = DIR_ACW; end
         3'b001: begin nb_pad = 2; edge_code = EDGE_TOP;    dir = DIR_CW;  end
         3'b010: begin nb_pad = 0; edge_code = EDGE_LEFT;   dir = DIR_CW;  end
         3'b011: begin nb_pad = 3; edge_code = EDGE_BOTTOM; dir = DIR_ACW; end
         3'b100: begin nb_pad = 0; edge_code = EDGE_TOP;    dir = DIR_ACW; end
         3'b101: begin nb_pad = 3; edge_code = EDGE_RIGHT;  dir = DIR_CW;  end
         3'b110: begin nb_pad = 1; edge_code = EDGE_BOTTOM; dir = DIR_CW;  end
         default: begin nb_pad = 2; edge_code = EDGE_RIGHT; dir = DIR_ACW; end
      endcase
   endtask

   // Advance the off-time counters of one face and queue the wipes the sample causes
   task automatic predict_wipes(input req_type req);
      int          face_idx;
      int          nb_pad;
      logic [1:0]  edge_code;
      logic        dir;
      rsp_type     wipe;
      rsp_type     found [$];
      face_idx = int'(req.face);
      if (face_idx < NUM_FACES) begin
         for (int p = 0; p < PADS; p++) begin
            if (req.pad_bits[p])
               off_time[face_idx][p] = 8'd0;
            else if (off_time[face_idx][p] < elapse_limit)
               off_time[face_idx][p] = off_time[face_idx][p] + 8'd1;
         end
         for (int p = 0; p < PADS; p++) begin
            if (req.pad_bits[p]) begin
               for (int j = 0; j < 2; j++) begin
                  neighbor_of(p, j, nb_pad, edge_code, dir);
                  if (off_time[face_idx][nb_pad] < elapse_limit) begin
                     if (found.size() < 4) begin
                        wipe.event_face = req.face;
                        wipe.edge_res   = edge_code;
                        wipe.direction  = dir;
                        wipe.last_event = 1'b0;
                        found.push_back(wipe);
                     end
                     off_time[face_idx][nb_pad] = elapse_limit;
                  end
               end
            end
         end
         if (found.size() > 0)
            found[found.size() - 1].last_event = 1'b1;
         foreach (found[k])
            expected_wipes.push_back(found[k]);
      end
   endtask

   task automatic compare_field(input string name, input int exp_val, input int act_val);
      if (exp_val != act_val) begin
         $display("%0t: wipe event field %s mismatch: expected %0d, actual %0d",
                  $time, name, exp_val, act_val);
         mismatches++;
      end
   endtask

   // Compare one popped event with the oldest expected one
   task automatic check_wipe(input rsp_type got);
      rsp_type want;
      if (expected_wipes.size() == 0) begin
         $display("%0t: unexpected wipe event: expected none, %s %0d edge %0d dir %0d last %0d",
                  $time, "actual face", got.event_face, got.edge_res, got.direction,
                  got.last_event);
         mismatches++;
      end else begin
         want = expected_wipes.pop_front();
         compare_field("event_face", want.event_face, got.event_face);
         compare_field("edge_res", want.edge_res, got.edge_res);
         compare_field("direction", want.direction, got.direction);
         compare_field("last_event", want.last_event, got.last_event);
         events_checked++;
      end
   endtask

   // Watch both channels and the register port on every rising edge
   always @(posedge clock) begin
      if (reset) begin
         for (int f = 0; f < NUM_FACES; f++)
            for (int p = 0; p < PADS; p++)
               off_time[f][p] = 8'hFF;
         elapse_limit = LIMIT_RESET;
         expected_wipes.delete();
      end else begin
         if (csr_we)
            elapse_limit = csr_wdata;
         if (rsp_pop && !rsp_empty)
            check_wipe(rsp_data);
         if (req_push && !req_full)
            predict_wipes(req_data);
      end
      pending = expected_wipes.size();
   end

endmodule

>>> tb/sv/touch_pad_wipe_detector_unit_test.sv
// Testbench top for the wipe detector: clock, reset, stimulus and verdict.
`timescale 1ns / 1ps

module touch_pad_wipe_detector_unit_test;
   import twpd_pkg::*;

   localparam int WATCHDOG_LIMIT = 5000;
   localparam int DRAIN_CYCLES   = 8;
   localparam int PHASE_ITEMS    = 60;
   localparam int NUM_PHASES     = 6;

   logic       clock;
   logic       reset;
   logic       req_push;
   logic       req_full;
   req_type    req_data;
   logic       rsp_empty;
   logic       rsp_pop = 1'b0;
   rsp_type    rsp_data;
   logic       csr_we;
   logic [7:0] csr_wdata;

   int pending;
   int mismatches;
   int events_checked;
   int requests_sent = 0;
   int send_idle_pct = 0;
   int pop_stall_pct = 0;
   int active_limit  = LIMIT_RESET;
   int quiet_cycles  = 0;

   touch_pad_wipe_detector_unit #(.NUM_FACES(2)) dut (
      .clock     (clock),
      .reset     (reset),
      .req_push  (req_push),
      .req_full  (req_full),
      .req_data  (req_data),
      .rsp_empty (rsp_empty),
      .rsp_pop   (rsp_pop),
      .rsp_data  (rsp_data),
      .csr_we    (csr_we),
      .csr_wdata (csr_wdata)
   );

   touch_pad_wipe_detector_unit_checker #(.NUM_FACES(2)) checker_inst (
      .clock          (clock),
      .reset          (reset),
      .req_push       (req_push),
      .req_full       (req_full),
      .req_data       (req_data),
      .rsp_empty      (rsp_empty),
      .rsp_pop        (rsp_pop),
      .rsp_data       (rsp_data),
      .csr_we         (csr_we),
      .csr_wdata      (csr_wdata),
      .pending        (pending),
      .mismatches     (mismatches),
      .events_checked (events_checked)
   );

   always begin
      clock = 1'b0;
      #1;
      clock = 1'b1;
      #1;
   end

   // Stall the result side at random
   always @(negedge clock) begin
      rsp_pop <= ($urandom_range(99) >= pop_stall_pct);
   end

   // End the run when nothing moves for too long
   always @(posedge clock) begin
      if (reset || (req_push && !req_full) || (rsp_pop && !rsp_empty))
         quiet_cycles = 0;
      else
         quiet_cycles++;
      if (quiet_cycles >= WATCHDOG_LIMIT) begin
         $display("%0t: no request or event moved for %0d cycles", $time, WATCHDOG_LIMIT);
         $display("[touch_pad_wipe_detector_unit] ERROR");
         $finish;
      end
   end

   // Hold one request until it is accepted, idling before it at random
   task automatic push_sample(input logic face, input logic [3:0] bits);
      while ($urandom_range(99) < send_idle_pct) begin
         @(negedge clock);
         req_push <= 1'b0;
      end
      @(negedge clock);
      req_push <= 1'b1;
      req_data <= '{face: face, pad_bits: bits};
      @(posedge clock);
      while (req_full)
         @(posedge clock);
      requests_sent++;
   endtask

   // Drop push and wait until every expected event has left the block
   task automatic drain();
      @(negedge clock);
      req_push <= 1'b0;
      while (pending != 0)
         @(negedge clock);
      repeat (DRAIN_CYCLES) @(negedge clock);
   endtask

   task automatic write_limit(input logic [7:0] value);
      drain();
      csr_we    <= 1'b1;
      csr_wdata <= value;
      active_limit = value;
      @(negedge clock);
      csr_we <= 1'b0;
   endtask

   // Touch a pad, release, then touch a neighbor, over a chain of steps
   task automatic wipe_burst();
      logic       face;
      logic [3:0] bits;
      int         pad;
      int         steps;
      int         gap;
      int         reach;
      face  = 1'($urandom_range(1));
      pad   = $urandom_range(3);
      steps = $urandom_range(2, 5);
      reach = (active_limit + 2 < 40) ? active_limit + 2 : 40;
      for (int s = 0; s < steps; s++) begin
         bits = 4'b0001 << pad;
         if ($urandom_range(9) == 0)
            bits = bits | 4'($urandom_range(15));
         repeat (1 + $urandom_range(2)) push_sample(face, bits);
         gap = ($urandom_range(3) == 0) ? $urandom_range(0, reach) : $urandom_range(0, 3);
         repeat (gap) push_sample(face, 4'b0000);
         pad = pad ^ (($urandom_range(1) == 1) ? 1 : 2);
      end
   endtask

   initial begin
      logic [4:0] warmup [$];
      logic [4:0] narrow [$];
      int         target;
      logic [7:0] lim;
      req_push  = 1'b0;
      req_data  = '0;
      csr_we    = 1'b0;
      csr_wdata = 8'd0;
      reset     = 1'b1;
      repeat (4) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // Directed samples at the reset limit: single pads, neighbor moves, all pads on
      warmup = '{5'h01, 5'h00, 5'h02, 5'h04, 5'h08, 5'h00, 5'h0F, 5'h0F, 5'h0A, 5'h05,
                 5'h18, 5'h10, 5'h14, 5'h10, 5'h11, 5'h12, 5'h13, 5'h1C, 5'h1F, 5'h00};
      foreach (warmup[i])
         push_sample(warmup[i][4], warmup[i][3:0]);

      // Smallest limit: only pads touched in the same sample can pair up
      write_limit(8'd1);
      narrow = '{5'h03, 5'h01, 5'h02, 5'h16};
      foreach (narrow[i])
         push_sample(narrow[i][4], narrow[i][3:0]);

      // Random phases: change the limit between phases and rotate the idle mix
      for (int ph = 0; ph < NUM_PHASES; ph++) begin
         case (ph)
            0: lim = 8'd254;
            1: lim = 8'd3;
            2: lim = 8'd1;
            3: lim = 8'($urandom_range(2, 40));
            4: lim = 8'd12;
            default: lim = LIMIT_RESET;
         endcase
         write_limit(lim);
         case (ph % 4)
            0: begin send_idle_pct = 0;  pop_stall_pct = 0;  end
            1: begin send_idle_pct = 49; pop_stall_pct = 0;  end
            2: begin send_idle_pct = 0;  pop_stall_pct = 49; end
            default: begin send_idle_pct = 24; pop_stall_pct = 24; end
         endcase
         target = requests_sent + PHASE_ITEMS;
         while (requests_sent < target) begin
            if ($urandom_range(3) == 0)
               push_sample(1'($urandom_range(1)), 4'($urandom_range(15)));
            else
               wipe_burst();
         end
      end

      send_idle_pct = 0;
      pop_stall_pct = 0;
      drain();

      $display("Covered %0d samples on both faces over eight limit settings from 1 to 254,",
               requests_sent);
      $display("with idle and stall mixes on both sides; %0d wipe events compared.",
               events_checked);
      if (mismatches == 0 && pending == 0) begin
         $display("[touch_pad_wipe_detector_unit] OK");
      end else begin
         $display("%0t: %0d mismatches, %0d expected events never arrived",
                  $time, mismatches, pending);
         $display("[touch_pad_wipe_detector_unit] ERROR");
      end
      $finish;
   end

endmodule

>>> files.f
src/twpd_pkg.sv
src/twpd_front.sv
src/twpd_queue.sv
src/twpd_back.sv
src/touch_pad_wipe_detector_unit.sv
tb/sv/touch_pad_wipe_detector_unit_checker.sv
tb/sv/touch_pad_wipe_detector_unit_test.sv
